// ===== rtl/core/mtfd_pkg.sv =====
// Package for the multi-type frame deframer.
// Holds the frame-format constants and the store port structs.
// No dependencies; used by the store, the top level and the testbench.
`default_nettype none

package mtfd_pkg;

    // Frame size limits
    localparam int RX_MAX      = 64;
    localparam int DB_MAX      = 64;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;

    // Marker bytes
    localparam logic [7:0] MARK_DB = 8'hdb;
    localparam logic [7:0] MARK_DD = 8'hdd;
    localparam logic [7:0] MARK_05 = 8'h05;
    localparam logic [7:0] MARK_15 = 8'h15;

    // Type byte range of 0x05 / 0x15 frames
    localparam logic [7:0] TYPE_LO = 8'h5a;
    localparam logic [7:0] TYPE_HI = 8'h5d;

    // Header lengths
    localparam logic [7:0]       DB_MIN_LEN = 8'd3;
    localparam logic [LEN_W-1:0] HDR_LEN    = LEN_W'(4);
    localparam logic [LEN_W-1:0] DD_LEN     = LEN_W'(4);

    localparam logic [30:0] IDLE_GAP_RESET = 31'd50;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } store_rd_t;

    function automatic logic is_marker(input logic [7:0] b);
        return (b == MARK_DB) || (b == MARK_DD) || (b == MARK_05) || (b == MARK_15);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtfd_store.sv =====
// Frame store of the deframer: one write port, one read port with registered data.
// Depends on mtfd_pkg for depth and port structs.
`default_nettype none

module mtfd_store
    import mtfd_pkg::*;
(
    input  wire logic      clk,
    input  wire store_wr_t wr,
    input  wire store_rd_t rd,
    output logic [7:0]     rdata
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/multi_type_frame_deframer_unit.sv =====
// Top level of the multi-type frame deframer.
// Depends on mtfd_pkg and instantiates mtfd_store.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat is either a link byte with its
//   millisecond timestamp (req_type 0) or a bare time check (req_type 1).
//   Output channel (out_valid/out_ready): result beats. An input that does not
//   finish a frame yields one status beat (has_byte 0, last 1). An input that
//   finishes a 0xdb, 0x05 or 0x15 frame yields one beat per frame byte, read
//   back from the frame store, with last on the final byte.
//   Every beat carries the four wrapping event counters.
//   Configuration: idle_gap_ms_we writes idle_gap_ms_wdata; write only when idle.
// Flow:
//   An input beat is handled in the cycle it is accepted; its status beat is
//   registered and appears on the output in the next cycle. With the receiver
//   ready and no readout under way, one input beat is taken per cycle. While a
//   completing frame reads out, the store read port (registered read data)
//   delivers one byte per cycle with the receiver ready, and no input is taken.
// Reset: rst_n clears the partial frame, the counters, the timestamp and the
//   output valid flag, and sets idle_gap_ms to 50; the store needs no clearing.
// Stall: while out_ready is low and a beat is held, the output register holds it,
//   the readout holds once its read stage is full, and in_ready stays low.
`default_nettype none

module multi_type_frame_deframer_unit
    import mtfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        idle_gap_ms_we,
    input  wire logic [30:0] idle_gap_ms_wdata,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [31:0] now_time,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             has_byte,
    output logic [7:0]       frame_byte,
    output logic [5:0]       byte_index,
    output logic             last,
    output logic [6:0]       frame_length,
    output logic [31:0]      frames_count,
    output logic [31:0]      malformed_count,
    output logic [31:0]      expired_count,
    output logic [31:0]      ignored_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // Control state
    logic             state_reg, state_next;
    logic [30:0]      idle_gap_reg;
    logic [LEN_W-1:0] held_reg, held_next;
    logic [LEN_W-1:0] tgt_reg, tgt_next;
    logic [31:0]      last_act_reg, last_act_next;
    logic [31:0]      frames_reg, frames_next;
    logic [31:0]      malformed_reg, malformed_next;
    logic [31:0]      expired_reg, expired_next;
    logic [31:0]      ignored_reg, ignored_next;

    // Header bytes kept beside the store
    logic [7:0]       first_reg, first_next;
    logic [7:0]       plen_lo_reg, plen_lo_next;

    // Readout
    logic [LEN_W-1:0] rd_len_reg, rd_len_next;
    logic [LEN_W-1:0] issue_reg, issue_next;
    logic             s1_vld_reg, s1_vld_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic             has_byte_reg, has_byte_next;
    logic [7:0]       byte_reg, byte_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      oc_frames_reg, oc_frames_next;
    logic [31:0]      oc_malformed_reg, oc_malformed_next;
    logic [31:0]      oc_expired_reg, oc_expired_next;
    logic [31:0]      oc_ignored_reg, oc_ignored_next;

    // Item handling
    logic             out_free;
    logic             in_acc;
    logic [31:0]      elapsed;
    logic             expire;
    logic [LEN_W-1:0] held1;
    logic [LEN_W-1:0] tgt1;
    logic [LEN_W-1:0] cnt;
    logic [LEN_W-1:0] new_tgt;
    logic [15:0]      payload;
    logic             bad;
    logic             reject;
    logic             status;
    logic             start_read;
    logic             s1_move;
    logic             issue;
    store_wr_t        st_wr;
    store_rd_t        st_rd;
    logic [7:0]       st_rdata;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = in_valid && in_ready;

    assign elapsed = now_time - last_act_reg;
    assign expire  = (held_reg != '0) && (elapsed >= {1'b0, idle_gap_reg});
    assign held1   = expire ? '0 : held_reg;
    assign tgt1    = expire ? '0 : tgt_reg;
    assign cnt     = held1 + LEN_W'(1);
    assign payload = {rx_byte, plen_lo_reg};

    // Per-item update of the partial frame and the counters
    always_comb
    begin
        held_next      = held_reg;
        tgt_next       = tgt_reg;
        last_act_next  = last_act_reg;
        frames_next    = frames_reg;
        malformed_next = malformed_reg;
        expired_next   = expired_reg;
        ignored_next   = ignored_reg;
        first_next     = first_reg;
        plen_lo_next   = plen_lo_reg;
        st_wr          = '0;
        bad            = 1'b0;
        reject         = 1'b0;
        new_tgt        = tgt1;
        status         = 1'b0;
        start_read     = 1'b0;

        if (in_acc)
        begin
            status    = 1'b1;
            held_next = held1;
            tgt_next  = tgt1;
            if (expire)
            begin
                expired_next = expired_reg + 32'd1;
            end

            if (req_type == 1'b0)
            begin
                if (held1 == '0)
                begin
                    // Open a frame on a marker, drop anything else
                    if (is_marker(rx_byte))
                    begin
                        st_wr         = '{en: 1'b1, addr: '0, data: rx_byte};
                        first_next    = rx_byte;
                        held_next     = LEN_W'(1);
                        tgt_next      = (rx_byte == MARK_DD) ? DD_LEN : '0;
                        last_act_next = now_time;
                    end
                end
                else
                begin
                    last_act_next = now_time;
                    if (held1 >= LEN_W'(RX_MAX))
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        st_wr = '{en: 1'b1, addr: held1[IDX_W-1:0], data: rx_byte};
                        if (cnt == LEN_W'(3))
                        begin
                            plen_lo_next = rx_byte;
                        end
                        if (first_reg == MARK_DB && cnt == LEN_W'(2))
                        begin
                            if (rx_byte < DB_MIN_LEN || rx_byte > 8'(DB_MAX))
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                new_tgt = rx_byte[LEN_W-1:0];
                            end
                        end
                        else if (first_reg == MARK_05 || first_reg == MARK_15)
                        begin
                            if (cnt == LEN_W'(2) &&
                                (rx_byte < TYPE_LO || rx_byte > TYPE_HI))
                            begin
                                bad = 1'b1;
                            end
                            if (cnt == HDR_LEN)
                            begin
                                if (payload > 16'(RX_MAX - 4))
                                begin
                                    bad = 1'b1;
                                end
                                else
                                begin
                                    new_tgt = payload[LEN_W-1:0] + HDR_LEN;
                                end
                            end
                        end

                        if (bad)
                        begin
                            reject = 1'b1;
                        end
                        else if (new_tgt != '0 && cnt == new_tgt)
                        begin
                            held_next = '0;
                            tgt_next  = '0;
                            if (first_reg == MARK_DD)
                            begin
                                ignored_next = ignored_reg + 32'd1;
                            end
                            else
                            begin
                                frames_next = frames_reg + 32'd1;
                                status      = 1'b0;
                                start_read  = 1'b1;
                            end
                        end
                        else
                        begin
                            held_next = cnt;
                            tgt_next  = new_tgt;
                        end
                    end

                    // Drop the partial frame; a marker reopens one
                    if (reject)
                    begin
                        malformed_next = malformed_reg + 32'd1;
                        held_next      = '0;
                        tgt_next       = '0;
                        if (is_marker(rx_byte))
                        begin
                            st_wr      = '{en: 1'b1, addr: '0, data: rx_byte};
                            first_next = rx_byte;
                            held_next  = LEN_W'(1);
                            tgt_next   = (rx_byte == MARK_DD) ? DD_LEN : '0;
                        end
                    end
                end
            end
        end
    end

    // Readout: store read stage feeding the output register
    assign s1_move = (state_reg == ST_READ) && s1_vld_reg && out_free;
    assign issue   = (state_reg == ST_READ) && (issue_reg < rd_len_reg) &&
                     (!s1_vld_reg || out_free);
    assign st_rd   = '{en: issue, addr: issue_reg[IDX_W-1:0]};

    always_comb
    begin
        state_next  = state_reg;
        rd_len_next = rd_len_reg;
        issue_next  = issue_reg;
        s1_vld_next = s1_vld_reg;
        s1_idx_next = s1_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_read)
                begin
                    state_next  = ST_READ;
                    rd_len_next = cnt;
                    issue_next  = '0;
                    s1_vld_next = 1'b0;
                end
            end
            ST_READ:
            begin
                if (issue)
                begin
                    s1_vld_next = 1'b1;
                    s1_idx_next = issue_reg[IDX_W-1:0];
                    issue_next  = issue_reg + LEN_W'(1);
                end
                else if (s1_move)
                begin
                    s1_vld_next = 1'b0;
                    if (issue_reg == rd_len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register load; a status beat and a readout beat never coincide
    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        has_byte_next     = has_byte_reg;
        byte_next         = byte_reg;
        index_next        = index_reg;
        last_next         = last_reg;
        len_next          = len_reg;
        oc_frames_next    = oc_frames_reg;
        oc_malformed_next = oc_malformed_reg;
        oc_expired_next   = oc_expired_reg;
        oc_ignored_next   = oc_ignored_reg;

        if (status)
        begin
            out_valid_next    = 1'b1;
            has_byte_next     = 1'b0;
            byte_next         = '0;
            index_next        = '0;
            last_next         = 1'b1;
            len_next          = '0;
            oc_frames_next    = frames_next;
            oc_malformed_next = malformed_next;
            oc_expired_next   = expired_next;
            oc_ignored_next   = ignored_next;
        end
        else if (s1_move)
        begin
            out_valid_next    = 1'b1;
            has_byte_next     = 1'b1;
            byte_next         = st_rdata;
            index_next        = s1_idx_reg;
            last_next         = (LEN_W'(s1_idx_reg) + LEN_W'(1)) == rd_len_reg;
            len_next          = rd_len_reg;
            oc_frames_next    = frames_reg;
            oc_malformed_next = malformed_reg;
            oc_expired_next   = expired_reg;
            oc_ignored_next   = ignored_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idle_gap_reg  <= IDLE_GAP_RESET;
            held_reg      <= '0;
            tgt_reg       <= '0;
            last_act_reg  <= '0;
            frames_reg    <= '0;
            malformed_reg <= '0;
            expired_reg   <= '0;
            ignored_reg   <= '0;
            rd_len_reg    <= '0;
            issue_reg     <= '0;
            s1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (idle_gap_ms_we)
            begin
                idle_gap_reg <= idle_gap_ms_wdata;
            end
            held_reg      <= held_next;
            tgt_reg       <= tgt_next;
            last_act_reg  <= last_act_next;
            frames_reg    <= frames_next;
            malformed_reg <= malformed_next;
            expired_reg   <= expired_next;
            ignored_reg   <= ignored_next;
            rd_len_reg    <= rd_len_next;
            issue_reg     <= issue_next;
            s1_vld_reg    <= s1_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        first_reg        <= first_next;
        plen_lo_reg      <= plen_lo_next;
        s1_idx_reg       <= s1_idx_next;
        has_byte_reg     <= has_byte_next;
        byte_reg         <= byte_next;
        index_reg        <= index_next;
        last_reg         <= last_next;
        len_reg          <= len_next;
        oc_frames_reg    <= oc_frames_next;
        oc_malformed_reg <= oc_malformed_next;
        oc_expired_reg   <= oc_expired_next;
        oc_ignored_reg   <= oc_ignored_next;
    end

    // Writes happen only on accepted input, reads only during readout,
    // so the two ports never touch the same entry in one cycle.
    mtfd_store u_store
    (
        .clk   (clk),
        .wr    (st_wr),
        .rd    (st_rd),
        .rdata (st_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign has_byte        = has_byte_reg;
    assign frame_byte      = byte_reg;
    assign byte_index      = index_reg;
    assign last            = last_reg;
    assign frame_length    = len_reg;
    assign frames_count    = oc_frames_reg;
    assign malformed_count = oc_malformed_reg;
    assign expired_count   = oc_expired_reg;
    assign ignored_count   = oc_ignored_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mtfd_checker.sv =====
// Port-level checker for the multi-type frame deframer, bound to the top level.
// Depends on multi_type_frame_deframer_unit ports only.
`default_nettype none

module mtfd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        has_byte,
    input wire logic [7:0]  frame_byte,
    input wire logic [5:0]  byte_index,
    input wire logic        last,
    input wire logic [6:0]  frame_length
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
        $stable(byte_index) && $stable(has_byte))
        else $error("result beat changed under stall");

    // Status beats are single and empty
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last && frame_length == 7'd0 &&
        byte_index == 6'd0)
        else $error("malformed status beat");

    // Frame bytes stay inside the frame
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> {1'b0, byte_index} < frame_length)
        else $error("byte index beyond frame length");

    // Final frame byte sits at the end
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte && last |-> ({1'b0, byte_index} + 7'd1) == frame_length)
        else $error("last flag on wrong byte");

    // No input taken while a frame is streaming out
    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte && !last |-> !in_ready)
        else $error("input taken during frame readout");

endmodule

bind multi_type_frame_deframer_unit mtfd_checker u_mtfd_checker (.*);

`default_nettype wire

// ===== test/multi_type_frame_deframer_unit_tb.sv =====
// Self-checking testbench for multi_type_frame_deframer_unit.
// Drives link bytes and time checks, predicts every result beat in place and
// compares it field by field. Depends on mtfd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module multi_type_frame_deframer_unit_tb
    import mtfd_pkg::*;
();

    // Worst case is far below this: a few hundred input beats, frames of at
    // most 64 bytes, and random stalls on either side.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 40;

    localparam logic [30:0] GAP_MIN = 31'd1;
    localparam logic [30:0] GAP_MAX = 31'h7fff_ffff;

    // Input beat kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Directed rows either carry a typed-in status beat or go to the predictor
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic        has;
        logic [7:0]  data;
        logic [5:0]  idx;
        logic        fin;
        logic [6:0]  len;
        logic [31:0] frames;
        logic [31:0] malformed;
        logic [31:0] expired;
        logic [31:0] ignored;
    } frame_beat_t;

    typedef struct packed {
        logic        rq;
        logic [7:0]  b;
        logic [31:0] t;
        logic        typed;
        logic [31:0] frames;
        logic [31:0] malformed;
        logic [31:0] expired;
        logic [31:0] ignored;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        idle_gap_ms_we;
    logic [30:0] idle_gap_ms_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_time;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        has_byte;
    logic [7:0]  frame_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [6:0]  frame_length;
    logic [31:0] frames_count;
    logic [31:0] malformed_count;
    logic [31:0] expired_count;
    logic [31:0] ignored_count;

    // Deframer shadow state, advanced once per accepted input beat
    logic [30:0] gap_ms;
    logic [7:0]  shadow_store [STORE_DEPTH];
    logic [6:0]  held;
    logic [6:0]  target;
    logic [31:0] last_seen;
    logic [31:0] frames_seen;
    logic [31:0] malformed_seen;
    logic [31:0] expired_seen;
    logic [31:0] ignored_seen;

    // Millisecond clock of the link; advances by a random step per beat
    logic [31:0] wall_ms;

    frame_beat_t predicted_beats [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          no_gaps = 1'b0;

    multi_type_frame_deframer_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .idle_gap_ms_we    (idle_gap_ms_we),
        .idle_gap_ms_wdata (idle_gap_ms_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .rx_byte           (rx_byte),
        .now_time          (now_time),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .has_byte          (has_byte),
        .frame_byte        (frame_byte),
        .byte_index        (byte_index),
        .last              (last),
        .frame_length      (frame_length),
        .frames_count      (frames_count),
        .malformed_count   (malformed_count),
        .expired_count     (expired_count),
        .ignored_count     (ignored_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic frame_beat_t status_beat(input logic [31:0] f, input logic [31:0] m,
                                                input logic [31:0] e, input logic [31:0] i);
        frame_beat_t beat;
        beat           = '0;
        beat.fin       = 1'b1;
        beat.frames    = f;
        beat.malformed = m;
        beat.expired   = e;
        beat.ignored   = i;
        return beat;
    endfunction

    function automatic void push_status();
        predicted_beats.push_back(status_beat(frames_seen, malformed_seen, expired_seen,
                                              ignored_seen));
    endfunction

    // A marker byte opens a frame; anything else is dropped.
    function automatic void open_frame(input logic [7:0] b, input logic [31:0] t);
        if (b == MARK_DB || b == MARK_DD || b == MARK_05 || b == MARK_15)
        begin
            shadow_store[0] = b;
            held            = 7'd1;
            last_seen       = t;
            if (b == MARK_DD)
                target = DD_LEN;
        end
    endfunction

    // Count the bad header, drop the partial frame, let the byte reopen one.
    function automatic void reject_and_reopen(input logic [7:0] b, input logic [31:0] t);
        malformed_seen++;
        held   = '0;
        target = '0;
        open_frame(b, t);
    endfunction

    // Work out the result beats of one accepted input beat.
    function automatic void deframe_beat(input logic rq, input logic [7:0] b,
                                         input logic [31:0] t);
        logic [7:0]  head;
        logic [15:0] payload;
        logic [6:0]  done_len;
        logic [31:0] elapsed;
        frame_beat_t beat;
        int          k;

        // Idle expiry uses the wrapping 32-bit distance to the last byte
        elapsed = t - last_seen;
        if (held != 0 && elapsed >= {1'b0, gap_ms})
        begin
            expired_seen++;
            held   = '0;
            target = '0;
        end
        if (rq == REQ_TICK)
        begin
            push_status();
            return;
        end
        if (held == 0)
        begin
            open_frame(b, t);
            push_status();
            return;
        end
        last_seen = t;
        if (held >= RX_MAX)
        begin
            reject_and_reopen(b, t);
            push_status();
            return;
        end
        shadow_store[held[5:0]] = b;
        held++;
        head = shadow_store[0];

        if (head == MARK_DB && held == 7'd2)
        begin
            if (b < DB_MIN_LEN || b > DB_MAX)
            begin
                reject_and_reopen(b, t);
                push_status();
                return;
            end
            target = b[6:0];
        end
        else if (head == MARK_05 || head == MARK_15)
        begin
            if (held == 7'd2 && (b < TYPE_LO || b > TYPE_HI))
            begin
                reject_and_reopen(b, t);
                push_status();
                return;
            end
            if (held == 7'd4)
            begin
                // Little-endian payload length in bytes three and four
                payload = {b, shadow_store[2]};
                if (payload > RX_MAX - 4)
                begin
                    reject_and_reopen(b, t);
                    push_status();
                    return;
                end
                target = payload[6:0] + HDR_LEN;
            end
        end

        if (target == 0 || held != target)
        begin
            push_status();
            return;
        end

        done_len = held;
        held     = '0;
        target   = '0;
        if (head == MARK_DD)
        begin
            ignored_seen++;
            push_status();
            return;
        end
        frames_seen++;
        for (k = 0; k < done_len; k++)
        begin
            beat           = status_beat(frames_seen, malformed_seen, expired_seen,
                                         ignored_seen);
            beat.has       = 1'b1;
            beat.data      = shadow_store[k];
            beat.idx       = 6'(k);
            beat.fin       = (k + 1 == done_len);
            beat.len       = done_len;
            predicted_beats.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Mostly short steps below the idle gap, now and then exactly at it, one
    // below it, or a wild jump that exercises the high timestamp bits.
    function automatic logic [31:0] next_time();
        logic [31:0] g;
        logic [31:0] step;
        int unsigned pick;
        g    = {1'b0, gap_ms};
        pick = $urandom_range(0, 99);
        if (pick < 80)
            step = $urandom_range(0, (g - 1 < 20) ? g - 1 : 20);
        else if (pick < 88)
            step = g - 1;
        else if (pick < 96)
            step = g;
        else
            step = $urandom();
        wall_ms = wall_ms + step;
        return wall_ms;
    endfunction

    function automatic void add_row(input logic rq, input logic [7:0] b, input logic [31:0] t,
                                    input logic typed, input logic [31:0] f,
                                    input logic [31:0] m, input logic [31:0] e,
                                    input logic [31:0] i);
        directed_rows.push_back({rq, b, t, typed, f, m, e, i});
    endfunction

    // Present one input beat, hold it until accepted, then predict its results.
    // A typed-in status beat replaces the predicted one for typed directed rows.
    task automatic send_beat(input logic rq, input logic [7:0] b, input logic [31:0] t,
                             input logic use_fixed, input frame_beat_t fixed);
        while (!no_gaps && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        rx_byte  <= b;
        now_time <= t;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_beat(rq, b, t);
        if (use_fixed)
            predicted_beats[predicted_beats.size() - 1] = fixed;
        @(negedge clk);
    endtask

    // Send one random sequence: mostly well-formed frames of every kind, some
    // with broken headers, truncated ones left to expire, and line noise.
    task automatic send_random_frame(output int counted);
        logic [7:0] seq [$];
        logic [7:0] b;
        int         kind;
        int         len;
        int         cut;
        counted = 0;
        kind    = $urandom_range(0, 99);
        if (kind < 30)
        begin
            len = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? DB_MAX : 3)
                                              : $urandom_range(3, 12);
            seq.push_back(MARK_DB);
            seq.push_back(8'(len));
            repeat (len - 2) seq.push_back(8'($urandom()));
        end
        else if (kind < 60)
        begin
            len = ($urandom_range(0, 11) == 0) ? RX_MAX - 4 : $urandom_range(0, 8);
            seq.push_back(($urandom_range(0, 1) == 1) ? MARK_05 : MARK_15);
            seq.push_back(8'($urandom_range(TYPE_LO, TYPE_HI)));
            seq.push_back(8'(len));
            seq.push_back(8'h00);
            repeat (len) seq.push_back(8'($urandom()));
        end
        else if (kind < 70)
        begin
            seq.push_back(MARK_DD);
            repeat (3) seq.push_back(8'($urandom()));
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    seq.push_back(MARK_DB);
                    if ($urandom_range(0, 1) == 1)
                        seq.push_back(8'($urandom_range(0, 2)));
                    else
                        seq.push_back(8'($urandom_range(DB_MAX + 1, 255)));
                end
                1:
                begin
                    do
                        b = 8'($urandom());
                    while (b >= TYPE_LO && b <= TYPE_HI);
                    seq.push_back(($urandom_range(0, 1) == 1) ? MARK_05 : MARK_15);
                    seq.push_back(b);
                end
                default:
                begin
                    // Payload length above the store limit
                    seq.push_back(MARK_15);
                    seq.push_back(8'($urandom_range(TYPE_LO, TYPE_HI)));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        seq.push_back(8'($urandom_range(RX_MAX - 3, 255)));
                        seq.push_back(8'h00);
                    end
                    else
                    begin
                        seq.push_back(8'($urandom()));
                        seq.push_back(8'($urandom_range(1, 255)));
                    end
                end
            endcase
            repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom()));
        end
        else if (kind < 90)
        begin
            // Truncated frame; the following traffic or a time check expires it
            len = $urandom_range(4, 12);
            seq.push_back(MARK_DB);
            seq.push_back(8'(len));
            repeat (len - 2) seq.push_back(8'($urandom()));
            cut = $urandom_range(1, len - 1);
            while (seq.size() > cut)
                void'(seq.pop_back());
        end
        else
        begin
            repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom()));
        end

        foreach (seq[i])
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_beat(REQ_TICK, 8'($urandom()), next_time(), 1'b0, '0);
                counted++;
            end
            send_beat(REQ_BYTE, seq[i], next_time(), 1'b0, '0);
            if (kind < 90)
                counted++;
        end
    endtask

    // Drop valid and hold off until every predicted beat has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (predicted_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_idle_gap(input logic [30:0] value);
        idle_gap_ms_we    <= 1'b1;
        idle_gap_ms_wdata <= value;
        @(negedge clk);
        idle_gap_ms_we    <= 1'b0;
        gap_ms = value;
    endtask

    // Drain, reprogram the idle gap, then run random sequences.
    task automatic run_phase(input logic [30:0] gap, input int quota);
        int done;
        int got;
        wait_drained();
        write_idle_gap(gap);
        done = 0;
        while (done < quota)
        begin
            send_random_frame(got);
            done += got;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Receiver stalls about one cycle in ten, except in the no-gap stretch
    always @(negedge clk)
    begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end

    // Compare every accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        frame_beat_t seen;
        frame_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {has_byte, frame_byte, byte_index, last, frame_length, frames_count,
                    malformed_count, expired_count, ignored_count};
            if (predicted_beats.size() == 0)
                report_mismatch("result beat with nothing pending", 32'(seen.has), 32'hx);
            else
            begin
                want = predicted_beats.pop_front();
                check_field("has_byte", 32'(seen.has), 32'(want.has));
                check_field("frame_byte", 32'(seen.data), 32'(want.data));
                check_field("byte_index", 32'(seen.idx), 32'(want.idx));
                check_field("last", 32'(seen.fin), 32'(want.fin));
                check_field("frame_length", 32'(seen.len), 32'(want.len));
                check_field("frames_count", seen.frames, want.frames);
                check_field("malformed_count", seen.malformed, want.malformed);
                check_field("expired_count", seen.expired, want.expired);
                check_field("ignored_count", seen.ignored, want.ignored);
            end
        end
    end

    // Hard stop if the block hangs
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d beats still pending", cycle_count,
                 predicted_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n             = 1'b0;
        idle_gap_ms_we    = 1'b0;
        idle_gap_ms_wdata = '0;
        in_valid          = 1'b0;
        req_type          = REQ_BYTE;
        rx_byte           = '0;
        now_time          = '0;

        gap_ms         = IDLE_GAP_RESET;
        held           = '0;
        target         = '0;
        last_seen      = '0;
        frames_seen    = '0;
        malformed_seen = '0;
        expired_seen   = '0;
        ignored_seen   = '0;
        wall_ms        = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset idle gap of 50 ms. Typed rows are status beats
        // whose counters follow directly from the row sequence.
        // Time check straight after reset, then a stray byte outside a frame
        add_row(REQ_TICK, 8'h00,    32'd0,  TYPED,     0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h00,    32'd1,  TYPED,     0, 0, 0, 0);
        // 0xdb with a length below three, then one above the store size
        add_row(REQ_BYTE, MARK_DB,  32'd2,  PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h02,    32'd3,  TYPED,     0, 1, 0, 0);
        add_row(REQ_BYTE, MARK_DB,  32'd4,  PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h41,    32'd5,  TYPED,     0, 2, 0, 0);
        // Shortest 0xdb frame
        add_row(REQ_BYTE, MARK_DB,  32'd6,  PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h03,    32'd7,  PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'hff,    32'd8,  PREDICTED, 0, 0, 0, 0);
        // Type byte just below the allowed range
        add_row(REQ_BYTE, MARK_05,  32'd9,  PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h59,    32'd10, TYPED,     1, 3, 0, 0);
        // 0x15 frame with top type and empty payload
        add_row(REQ_BYTE, MARK_15,  32'd11, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, TYPE_HI,  32'd12, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h00,    32'd13, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h00,    32'd14, PREDICTED, 0, 0, 0, 0);
        // Payload length one past the limit
        add_row(REQ_BYTE, MARK_05,  32'd15, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, TYPE_LO,  32'd16, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h3d,    32'd17, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h00,    32'd18, TYPED,     2, 4, 0, 0);
        // 0xdd frame is counted and dropped
        add_row(REQ_BYTE, MARK_DD,  32'd19, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h11,    32'd20, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h22,    32'd21, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, 8'h33,    32'd22, TYPED,     2, 4, 0, 1);
        // Idle gap one short of expiry, then exactly at it
        add_row(REQ_BYTE, MARK_DB,  32'd23, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_TICK, 8'hff,    32'd72, TYPED,     2, 4, 0, 1);
        add_row(REQ_TICK, 8'h00,    32'd73, TYPED,     2, 4, 1, 1);
        // Bad type byte that is itself a marker reopens a frame
        add_row(REQ_BYTE, MARK_05,  32'd80, PREDICTED, 0, 0, 0, 0);
        add_row(REQ_BYTE, MARK_DB,  32'd81, TYPED,     2, 5, 1, 1);
        // Largest timestamp expires it
        add_row(REQ_TICK, 8'h00,    32'hffff_ffff, TYPED, 2, 5, 2, 1);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].rq, directed_rows[i].b, directed_rows[i].t,
                      directed_rows[i].typed,
                      status_beat(directed_rows[i].frames, directed_rows[i].malformed,
                                  directed_rows[i].expired, directed_rows[i].ignored));
        end
        wall_ms = 32'hffff_ffff;

        // Random phases over the range of idle gaps; the sender drains the
        // block before each register write. Run the widest gap without any
        // idling on either side.
        run_phase(GAP_MIN, PHASE_ITEMS);
        no_gaps = 1'b1;
        run_phase(GAP_MAX, PHASE_ITEMS);
        no_gaps = 1'b0;
        run_phase(31'($urandom_range(2, 5000)), PHASE_ITEMS);
        run_phase(IDLE_GAP_RESET, PHASE_ITEMS);

        // Let the last frame read out, then watch for stray beats
        wait_drained();
        repeat (80) @(negedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mtfd_pkg.sv
rtl/core/mtfd_store.sv
rtl/core/multi_type_frame_deframer_unit.sv
rtl/core/mtfd_checker.sv
test/multi_type_frame_deframer_unit_tb.sv
